/* rtl/cepstral_delta_and_delta_delta_unit_macros.svh */
`ifndef CEPSTRAL_DELTA_AND_DELTA_DELTA_UNIT_MACROS_SVH
`define CEPSTRAL_DELTA_AND_DELTA_DELTA_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CDD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cdd_pkg.sv */
`default_nettype none

package cdd_pkg;

    localparam int COEFF_W     = 16;
    localparam int OUT_IDX_W   = 5;
    // |n| + 5 stays below 2^18 for 16-bit samples
    localparam int MAG_W       = 18;
    // floor(a / 10) == (a * ceil(2^22 / 10)) >> 22 for all a below 2^19
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP_DIV10 = 19'd419431;
    localparam logic [MAG_W-1:0]   ROUND_BIAS  = 18'd5;

    typedef logic signed [COEFF_W-1:0] coeff_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_PASS1 = 3'b010,
        ST_PASS2 = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* rtl/cepstral_delta_and_delta_delta_unit.sv */
`default_nettype none

// Loads NUM_COEFFS cepstral coefficients (signed Q7.8), one per start beat,
// at one beat per cycle while busy is low. The beat that completes a vector
// raises busy; the unit then makes two passes over its single-port stores:
// one reads the coefficients and writes the deltas, the other reads the
// deltas and emits one result beat per cycle in index order, with
// last_result on the final index. Each pass streams NUM_COEFFS + 4 reads
// through a five-tap window and a three-stage divide-by-ten pipeline. The
// receiver cannot stall: each result is valid for the one cycle that
// result_valid is high.

`include "cepstral_delta_and_delta_delta_unit_macros.svh"

module cepstral_delta_and_delta_delta_unit #(
    parameter int NUM_COEFFS = 26
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire cdd_pkg::coeff_t                 coeff_value,
    output logic                                 result_valid,
    output logic [cdd_pkg::OUT_IDX_W-1:0]        coeff_index,
    output cdd_pkg::coeff_t                      delta_value,
    output cdd_pkg::coeff_t                      delta_delta_value,
    output logic                                 last_result
);

    localparam int IDX_W    = $clog2(NUM_COEFFS);
    localparam int CNT_W    = $clog2(NUM_COEFFS + 5);
    localparam int RD_TOTAL = NUM_COEFFS + 4;

    cdd_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] load_count_reg, load_count_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0] rd_k_reg;
    logic             rd_vld_reg;

    cdd_pkg::coeff_t coeff_mem [NUM_COEFFS];
    cdd_pkg::coeff_t delta_mem [NUM_COEFFS];
    cdd_pkg::coeff_t coeff_rd_reg;
    cdd_pkg::coeff_t delta_rd_reg;

    logic             accept;
    logic             rd_issue;
    logic [CNT_W-1:0] rd_pos;
    logic [CNT_W-1:0] rd_clamp;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] win_k;
    logic             win_vld;
    cdd_pkg::coeff_t  smp_data;

    logic             res_vld;
    logic [IDX_W-1:0] res_idx;
    cdd_pkg::coeff_t  res_center;
    cdd_pkg::coeff_t  res_value;
    logic             res_last;

    assign busy     = (state_reg != cdd_pkg::ST_LOAD);
    assign accept   = start && !busy;
    assign rd_issue = busy && (rd_cnt_reg != CNT_W'(RD_TOTAL));
    assign res_last = (res_idx == IDX_W'(NUM_COEFFS - 1));

    // window position k reads entry k - 2, replicated at both edges
    always_comb
    begin
        rd_pos = rd_cnt_reg - CNT_W'(2);
        if (rd_cnt_reg < CNT_W'(2))
            rd_clamp = '0;
        else if (rd_pos > CNT_W'(NUM_COEFFS - 1))
            rd_clamp = CNT_W'(NUM_COEFFS - 1);
        else
            rd_clamp = rd_pos;
        rd_addr = rd_clamp[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            coeff_mem[load_count_reg] <= coeff_value;
        if (rd_issue)
            coeff_rd_reg <= coeff_mem[rd_addr];
    end

    // deltas are written only in the first pass and read only in the second
    always_ff @(posedge clk)
    begin
        if (res_vld && state_reg == cdd_pkg::ST_PASS1)
            delta_mem[res_idx] <= res_value;
        if (rd_issue && state_reg == cdd_pkg::ST_PASS2)
            delta_rd_reg <= delta_mem[rd_addr];
    end

    assign smp_data = (state_reg == cdd_pkg::ST_PASS2) ? delta_rd_reg : coeff_rd_reg;
    assign win_k    = rd_k_reg - CNT_W'(4);
    assign win_vld  = rd_vld_reg && (rd_k_reg >= CNT_W'(4));

    cdd_regress #(
        .IDX_W (IDX_W)
    ) u_regress (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp_vld    (rd_vld_reg),
        .smp_data   (smp_data),
        .win_vld    (win_vld),
        .win_idx    (win_k[IDX_W-1:0]),
        .res_vld    (res_vld),
        .res_idx    (res_idx),
        .res_center (res_center),
        .res_value  (res_value)
    );

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        rd_cnt_next     = rd_issue ? rd_cnt_reg + CNT_W'(1) : rd_cnt_reg;
        unique case (state_reg)
            cdd_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (load_count_reg == IDX_W'(NUM_COEFFS - 1))
                    begin
                        load_count_next = '0;
                        rd_cnt_next     = '0;
                        state_next      = cdd_pkg::ST_PASS1;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + IDX_W'(1);
                    end
                end
            end
            cdd_pkg::ST_PASS1:
            begin
                // last delta written at this edge: start reading deltas
                if (res_vld && res_last)
                begin
                    rd_cnt_next = '0;
                    state_next  = cdd_pkg::ST_PASS2;
                end
            end
            cdd_pkg::ST_PASS2:
            begin
                if (res_vld && res_last)
                begin
                    rd_cnt_next = '0;
                    state_next  = cdd_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = cdd_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdd_pkg::ST_LOAD;
            load_count_reg <= '0;
            rd_cnt_reg     <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_vld_reg     <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
            rd_k_reg <= rd_cnt_reg;
    end

    assign result_valid      = res_vld && (state_reg == cdd_pkg::ST_PASS2);
    assign coeff_index       = cdd_pkg::OUT_IDX_W'(res_idx);
    assign delta_value       = res_center;
    assign delta_delta_value = res_value;
    assign last_result       = result_valid && res_last;

    `CDD_ASSERT_NEXT(a_busy_after_full,
        accept && load_count_reg == IDX_W'(NUM_COEFFS - 1), busy,
        "vector complete but unit not busy")
    `CDD_ASSERT_SAME(a_result_when_busy, result_valid, busy, "result beat while loading")
    `CDD_ASSERT_NEXT(a_idle_after_last, result_valid && last_result, !busy,
        "unit still busy after last result")
    `CDD_ASSERT_NEXT(a_results_back_to_back, result_valid && !last_result,
        result_valid && coeff_index == $past(coeff_index) + cdd_pkg::OUT_IDX_W'(1),
        "result beats not consecutive")

endmodule

`default_nettype wire

/* rtl/cdd_regress.sv */
`default_nettype none

module cdd_regress #(
    parameter int IDX_W = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 smp_vld,
    input  wire cdd_pkg::coeff_t      smp_data,
    input  wire logic                 win_vld,
    input  wire logic [IDX_W-1:0]     win_idx,
    output logic                      res_vld,
    output logic [IDX_W-1:0]          res_idx,
    output cdd_pkg::coeff_t           res_center,
    output cdd_pkg::coeff_t           res_value
);

    localparam int PROD_W = cdd_pkg::MAG_W + cdd_pkg::RECIP_W;
    localparam int QUOT_W = PROD_W - cdd_pkg::RECIP_SHIFT;

    // tap 0 is the newest stored sample, smp_data is newer still
    cdd_pkg::coeff_t tap_reg [4];

    logic signed [cdd_pkg::COEFF_W:0]   diff_near;
    logic signed [cdd_pkg::COEFF_W:0]   diff_far;
    logic signed [cdd_pkg::COEFF_W+2:0] num;
    logic        [cdd_pkg::COEFF_W+2:0] mag_full;
    logic        [cdd_pkg::MAG_W-1:0]   mag_bias;

    logic                      s1_vld_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic                      s1_neg_reg;
    cdd_pkg::coeff_t           s1_center_reg;
    logic [cdd_pkg::MAG_W-1:0] s1_mag_reg;

    logic                      s2_vld_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic                      s2_neg_reg;
    cdd_pkg::coeff_t           s2_center_reg;
    logic [PROD_W-1:0]         s2_prod_reg;

    logic [QUOT_W-1:0]         quot;
    cdd_pkg::coeff_t           quot_ext;

    logic                      s3_vld_reg;
    logic [IDX_W-1:0]          s3_idx_reg;
    cdd_pkg::coeff_t           s3_center_reg;
    cdd_pkg::coeff_t           s3_value_reg;

    always_ff @(posedge clk)
    begin
        if (smp_vld)
        begin
            tap_reg[0] <= smp_data;
            tap_reg[1] <= tap_reg[0];
            tap_reg[2] <= tap_reg[1];
            tap_reg[3] <= tap_reg[2];
        end
    end

    always_comb
    begin
        diff_near = (cdd_pkg::COEFF_W+1)'(tap_reg[0]) - (cdd_pkg::COEFF_W+1)'(tap_reg[2]);
        diff_far  = (cdd_pkg::COEFF_W+1)'(smp_data) - (cdd_pkg::COEFF_W+1)'(tap_reg[3]);
        num       = (cdd_pkg::COEFF_W+3)'(diff_near) + ((cdd_pkg::COEFF_W+3)'(diff_far) <<< 1);
        mag_full  = num[cdd_pkg::COEFF_W+2] ? (cdd_pkg::COEFF_W+3)'(-num)
                                            : (cdd_pkg::COEFF_W+3)'(num);
        mag_bias  = mag_full[cdd_pkg::MAG_W-1:0] + cdd_pkg::ROUND_BIAS;
        quot      = s2_prod_reg[PROD_W-1:cdd_pkg::RECIP_SHIFT];
        quot_ext  = cdd_pkg::COEFF_W'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= win_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= win_idx;
        s1_neg_reg    <= num[cdd_pkg::COEFF_W+2];
        s1_center_reg <= tap_reg[1];
        s1_mag_reg    <= mag_bias;

        s2_idx_reg    <= s1_idx_reg;
        s2_neg_reg    <= s1_neg_reg;
        s2_center_reg <= s1_center_reg;
        s2_prod_reg   <= PROD_W'(s1_mag_reg) * PROD_W'(cdd_pkg::RECIP_DIV10);

        // quotient fits in 15 bits, so the signed result never saturates
        s3_idx_reg    <= s2_idx_reg;
        s3_center_reg <= s2_center_reg;
        s3_value_reg  <= s2_neg_reg ? -quot_ext : quot_ext;
    end

    assign res_vld    = s3_vld_reg;
    assign res_idx    = s3_idx_reg;
    assign res_center = s3_center_reg;
    assign res_value  = s3_value_reg;

endmodule

`default_nettype wire
